// File: hw/rtl/pwsr_pkg.sv
// Package with the shared types and constants of the pulse-width serial receiver.
package pwsr_pkg;

  localparam int unsigned MaxFrameBytes = 64;

  localparam logic [7:0] TimeoutReset  = 8'd255;
  localparam logic [6:0] MaxBytesReset = 7'd64;
  localparam logic [6:0] FrameCap      = 7'(MaxFrameBytes > 127 ? 127 : MaxFrameBytes);
  localparam logic [3:0] BitsPerByte   = 4'd8;

  localparam int unsigned AddrWidth = 3;
  localparam logic RegTimeout  = 1'b0;
  localparam logic RegMaxBytes = 1'b1;

  typedef enum logic [1:0] {
    PhIdle,
    PhPreamble,
    PhHigh,
    PhLow
  } phase_e;

  typedef enum logic {
    KindData  = 1'b0,
    KindAbort = 1'b1
  } kind_e;

  typedef struct packed {
    logic [7:0] timeout_ticks;
    logic [6:0] max_bytes;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    kind_e      kind;
    logic [7:0] data_byte;
    logic [5:0] byte_index;
    logic       last_byte;
  } result_t;

endpackage

// File: hw/rtl/pwsr_if.sv
// Handshake interfaces for the sample input and the result output.
interface pwsr_in_if;
  logic valid;
  logic ready;
  logic line_level;

  modport source (output valid, output line_level, input ready);
  modport sink (input valid, input line_level, output ready);
endinterface

interface pwsr_out_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [7:0] data_byte;
  logic [5:0] byte_index;
  logic       last_byte;

  modport source (output valid, output result_kind, output data_byte, output byte_index,
                  output last_byte, input ready);
  modport sink (input valid, input result_kind, input data_byte, input byte_index,
                input last_byte, output ready);
endinterface

// File: hw/rtl/pwsr_regs.sv
// APB-style configuration registers of the receiver.
module pwsr_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pwsr_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output pwsr_pkg::cfg_t                 cfg_o
);

  pwsr_pkg::cfg_t cfg_q, cfg_d;
  logic           wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[2])
        pwsr_pkg::RegTimeout:  cfg_d.timeout_ticks = pwdata[7:0];
        pwsr_pkg::RegMaxBytes: cfg_d.max_bytes     = pwdata[6:0];
        default:               cfg_d               = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_ticks <= pwsr_pkg::TimeoutReset;
      cfg_q.max_bytes     <= pwsr_pkg::MaxBytesReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    unique case (paddr[2])
      pwsr_pkg::RegTimeout:  prdata = {24'd0, cfg_q.timeout_ticks};
      pwsr_pkg::RegMaxBytes: prdata = {25'd0, cfg_q.max_bytes};
      default:               prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// File: hw/rtl/pwsr_decoder.sv
// Frame state machine, phase counters and bit decision of the receiver.
module pwsr_decoder (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              level_i,
  input  pwsr_pkg::cfg_t    cfg_i,
  output pwsr_pkg::result_t res_o
);

  pwsr_pkg::phase_e phase_q, phase_d;
  logic             prev_q, prev_d;
  logic [7:0]       high_q, high_d;
  logic [7:0]       low_q, low_d;
  logic [3:0]       frag_q, frag_d;
  logic [7:0]       shift_q, shift_d;
  logic [6:0]       bytes_q, bytes_d;

  logic [8:0] sum;
  logic       bit_val;
  logic [6:0] cap;
  logic [7:0] idx_next;
  logic       low_timeout;
  logic       high_timeout;

  assign sum          = {1'b0, high_q} + {1'b0, low_q};
  assign bit_val      = high_q > sum[8:1];
  assign low_timeout  = low_q >= cfg_i.timeout_ticks;
  assign high_timeout = high_q >= cfg_i.timeout_ticks;
  assign idx_next     = {1'b0, bytes_q} + 8'd1;

  always_comb begin
    cap = (cfg_i.max_bytes > pwsr_pkg::FrameCap) ? pwsr_pkg::FrameCap : cfg_i.max_bytes;
    if (cap == 7'd0) begin
      cap = 7'd1;
    end
  end

  always_comb begin
    phase_d = phase_q;
    prev_d  = level_i;
    high_d  = high_q;
    low_d   = low_q;
    frag_d  = frag_q;
    shift_d = shift_q;
    bytes_d = bytes_q;
    res_o   = '0;
    unique case (phase_q)
      pwsr_pkg::PhIdle: begin
        if (prev_q && !level_i) begin
          phase_d = pwsr_pkg::PhPreamble;
          low_d   = 8'd1;
          high_d  = 8'd0;
          frag_d  = 4'd0;
          shift_d = 8'd0;
          bytes_d = 7'd0;
        end
      end
      pwsr_pkg::PhPreamble, pwsr_pkg::PhLow: begin
        if (!level_i) begin
          if (low_timeout) begin
            phase_d          = pwsr_pkg::PhIdle;
            res_o.valid      = 1'b1;
            res_o.kind       = pwsr_pkg::KindAbort;
            res_o.last_byte  = 1'b1;
          end else begin
            low_d = low_q + 8'd1;
          end
        end else begin
          phase_d = pwsr_pkg::PhHigh;
          high_d  = 8'd1;
          if (phase_q == pwsr_pkg::PhLow) begin
            if (frag_q < pwsr_pkg::BitsPerByte) begin
              shift_d = {shift_q[6:0], bit_val};
              frag_d  = frag_q + 4'd1;
            end else begin
              bytes_d          = bytes_q + 7'd1;
              res_o.valid      = 1'b1;
              res_o.kind       = pwsr_pkg::KindData;
              res_o.data_byte  = shift_q;
              res_o.byte_index = bytes_q[5:0];
              res_o.last_byte  = bit_val || (idx_next >= {1'b0, cap});
              frag_d           = 4'd0;
              shift_d          = 8'd0;
              if (res_o.last_byte) begin
                phase_d = pwsr_pkg::PhIdle;
              end
            end
          end
        end
      end
      pwsr_pkg::PhHigh: begin
        if (level_i) begin
          if (high_timeout) begin
            phase_d          = pwsr_pkg::PhIdle;
            res_o.valid      = 1'b1;
            res_o.kind       = pwsr_pkg::KindAbort;
            res_o.last_byte  = 1'b1;
          end else begin
            high_d = high_q + 8'd1;
          end
        end else begin
          phase_d = pwsr_pkg::PhLow;
          low_d   = 8'd1;
        end
      end
      default: phase_d = pwsr_pkg::PhIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= pwsr_pkg::PhIdle;
      prev_q  <= 1'b1;
      high_q  <= 8'd0;
      low_q   <= 8'd0;
      frag_q  <= 4'd0;
      shift_q <= 8'd0;
      bytes_q <= 7'd0;
    end else if (step_i) begin
      phase_q <= phase_d;
      prev_q  <= prev_d;
      high_q  <= high_d;
      low_q   <= low_d;
      frag_q  <= frag_d;
      shift_q <= shift_d;
      bytes_q <= bytes_d;
    end
  end

endmodule

// File: hw/rtl/pulse_width_serial_receiver.sv
// Top level of the pulse-width serial receiver: sample register, decoder and result register.
// A sample is registered on acceptance and then decoded; its result word is captured in the
// result register when the decoder advances.
// Throughput: one sample per cycle unless held back as below; the decoder state update sets it.
// A waiting result word holds back only a sample that itself produces a word.
// Reset clears the frame state to idle with the line taken as high, and restores
// the timeout to 255 and the byte capacity to 64.
module pulse_width_serial_receiver (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  pwsr_in_if.sink                        in_sink,
  pwsr_out_if.source                     out_source,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pwsr_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  pwsr_pkg::cfg_t    cfg;
  pwsr_pkg::result_t res;

  logic       in_valid_q;
  logic       level_q;
  logic       out_free;
  logic       advance;
  logic       out_valid_q;
  logic       kind_q;
  logic [7:0] data_q;
  logic [5:0] index_q;
  logic       last_q;

  pwsr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pwsr_decoder u_decoder (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .level_i (level_q),
    .cfg_i   (cfg),
    .res_o   (res)
  );

  assign out_free      = !out_valid_q || out_source.ready;
  assign advance       = in_valid_q && (!res.valid || out_free);
  assign in_sink.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_sink.ready) begin
      in_valid_q <= in_sink.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_sink.ready && in_sink.valid) begin
      level_q <= in_sink.line_level;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_source.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.valid) begin
      kind_q  <= res.kind;
      data_q  <= res.data_byte;
      index_q <= res.byte_index;
      last_q  <= res.last_byte;
    end
  end

  assign out_source.valid       = out_valid_q;
  assign out_source.result_kind = kind_q;
  assign out_source.data_byte   = data_q;
  assign out_source.byte_index  = index_q;
  assign out_source.last_byte   = last_q;

endmodule

// File: test/pulse_width_serial_receiver_tb.sv
// Self-checking testbench: random pulse frames into the receiver, checked by a predictor.
module pulse_width_serial_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit     = 600_000;
  localparam int unsigned DrainCycles    = 4;
  localparam int unsigned RandomSamples  = 950;
  localparam int unsigned RandomWords    = 40;
  localparam int unsigned ReportedErrors = 10;

  localparam logic [pwsr_pkg::AddrWidth-1:0] TimeoutAddr  =
    {pwsr_pkg::RegTimeout, 2'b00};
  localparam logic [pwsr_pkg::AddrWidth-1:0] CapacityAddr =
    {pwsr_pkg::RegMaxBytes, 2'b00};

  class frame_word_scoreboard;
    pwsr_pkg::result_t expected_words[$];
    logic [7:0]        tick_limit;
    logic [6:0]        byte_capacity;
    logic              last_level;
    pwsr_pkg::phase_e  decode_phase;
    logic [7:0]        high_count;
    logic [7:0]        low_count;
    logic [3:0]        fragments;
    logic [7:0]        shift_reg;
    logic [6:0]        byte_count;
    int unsigned       samples;
    int unsigned       words_checked;
    int unsigned       bytes_predicted;
    int unsigned       aborts_predicted;
    int unsigned       errors;

    function new();
      tick_limit    = pwsr_pkg::TimeoutReset;
      byte_capacity = pwsr_pkg::MaxBytesReset;
      last_level    = 1'b1;
      decode_phase  = pwsr_pkg::PhIdle;
      high_count    = '0;
      low_count     = '0;
      fragments     = '0;
      shift_reg     = '0;
      byte_count    = '0;
    endfunction

    function bit phase_expired(ref logic [7:0] count);
      if (count >= tick_limit) return 1'b1;
      count = count + 8'd1;
      return 1'b0;
    endfunction

    function void push_abort();
      pwsr_pkg::result_t w;
      w = '0;
      w.valid      = 1'b1;
      w.kind       = pwsr_pkg::KindAbort;
      w.last_byte  = 1'b1;
      decode_phase = pwsr_pkg::PhIdle;
      aborts_predicted++;
      expected_words.push_back(w);
    endfunction

    function void note_sample(logic level);
      pwsr_pkg::result_t w;
      logic              prev;
      logic              bit_val;
      int                sum;
      int                cap;
      prev       = last_level;
      last_level = level;
      samples++;
      case (decode_phase)
        pwsr_pkg::PhIdle: begin
          if (prev && !level) begin
            decode_phase = pwsr_pkg::PhPreamble;
            low_count    = 8'd1;
            high_count   = '0;
            fragments    = '0;
            shift_reg    = '0;
            byte_count   = '0;
          end
        end
        pwsr_pkg::PhPreamble: begin
          if (!level) begin
            if (phase_expired(low_count)) push_abort();
          end else begin
            decode_phase = pwsr_pkg::PhHigh;
            high_count   = 8'd1;
          end
        end
        pwsr_pkg::PhHigh: begin
          if (level) begin
            if (phase_expired(high_count)) push_abort();
          end else begin
            decode_phase = pwsr_pkg::PhLow;
            low_count    = 8'd1;
          end
        end
        default: begin
          if (!level) begin
            if (phase_expired(low_count)) push_abort();
          end else begin
            sum          = int'(high_count) + int'(low_count);
            bit_val      = (int'(high_count) > (sum >> 1));
            decode_phase = pwsr_pkg::PhHigh;
            high_count   = 8'd1;
            if (fragments < pwsr_pkg::BitsPerByte) begin
              shift_reg = {shift_reg[6:0], bit_val};
              fragments = fragments + 4'd1;
            end else begin
              cap = (byte_capacity > pwsr_pkg::MaxFrameBytes) ?
                    pwsr_pkg::MaxFrameBytes : int'(byte_capacity);
              if (cap == 0) cap = 1;
              w = '0;
              w.valid      = 1'b1;
              w.kind       = pwsr_pkg::KindData;
              w.data_byte  = shift_reg;
              w.byte_index = byte_count[5:0];
              w.last_byte  = bit_val || (int'(byte_count) + 1 >= cap);
              expected_words.push_back(w);
              bytes_predicted++;
              byte_count = byte_count + 7'd1;
              fragments  = '0;
              shift_reg  = '0;
              if (w.last_byte) decode_phase = pwsr_pkg::PhIdle;
            end
          end
        end
      endcase
    endfunction

    function void check_word(pwsr_pkg::result_t got);
      pwsr_pkg::result_t want;
      words_checked++;
      if (expected_words.size() == 0) begin
        errors++;
        if (errors <= ReportedErrors) begin
          $display("Unexpected word: kind %0d byte %02h index %0d last %0b",
                   got.kind, got.data_byte, got.byte_index, got.last_byte);
        end
        return;
      end
      want = expected_words.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= ReportedErrors) begin
          $display("Word mismatch: expected kind %0d byte %02h index %0d last %0b",
                   want.kind, want.data_byte, want.byte_index, want.last_byte);
          $display("               got kind %0d byte %02h index %0d last %0b",
                   got.kind, got.data_byte, got.byte_index, got.last_byte);
        end
      end
    endfunction
  endclass

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [pwsr_pkg::AddrWidth-1:0] paddr;
  logic [31:0]                    pwdata;
  logic [31:0]                    prdata;
  logic                           pready;

  pwsr_in_if  in_bus ();
  pwsr_out_if out_bus ();

  frame_word_scoreboard word_sb = new();

  logic [7:0]  cur_timeout = pwsr_pkg::TimeoutReset;
  bit          steady_in;
  bit          steady_out;
  int unsigned cycle_count;
  int unsigned settings_run;

  pulse_width_serial_receiver u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_sink    (in_bus),
    .out_source (out_bus),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Run stopped after %0d cycles with %0d words outstanding",
               cycle_count, word_sb.expected_words.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    pwsr_pkg::result_t got;
    if (rst_ni) begin
      if (out_bus.valid && out_bus.ready) begin
        got            = '0;
        got.valid      = 1'b1;
        got.kind       = pwsr_pkg::kind_e'(out_bus.result_kind);
        got.data_byte  = out_bus.data_byte;
        got.byte_index = out_bus.byte_index;
        got.last_byte  = out_bus.last_byte;
        word_sb.check_word(got);
      end
      if (in_bus.valid && in_bus.ready) word_sb.note_sample(in_bus.line_level);
    end
  end

  initial begin
    int stall;
    out_bus.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if ($urandom_range(0, 15) == 0) steady_out = !steady_out;
      stall = steady_out ? 0 : $urandom_range(0, 6);
      repeat (stall) begin
        @(negedge clk_i);
        out_bus.ready <= 1'b0;
      end
      @(negedge clk_i);
      out_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!out_bus.valid);
    end
  end

  task automatic send_sample(input logic level);
    int gap;
    gap = steady_in ? 0 : $urandom_range(0, 6);
    repeat (gap) begin
      @(negedge clk_i);
      in_bus.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_bus.valid      <= 1'b1;
    in_bus.line_level <= level;
    do @(posedge clk_i); while (!in_bus.ready);
  endtask

  task automatic send_run(input logic level, input int n);
    repeat (n) send_sample(level);
  endtask

  task automatic send_fragment(input int h, input int l);
    send_run(1'b1, h);
    send_run(1'b0, l);
  endtask

  task automatic send_byte(input logic [7:0] value, input logic flag);
    for (int i = 7; i >= 0; i--) send_fragment(value[i] ? 2 : 1, 1);
    send_fragment(flag ? 2 : 1, 1);
  endtask

  function automatic int phase_len(input int span);
    int lim;
    lim = (cur_timeout == 0) ? 1 : int'(cur_timeout);
    if (span > 1 && $urandom_range(0, 99) == 0) return lim;
    return $urandom_range(1, (span < lim) ? span : lim);
  endfunction

  task automatic send_frame(input int n_bytes, input int span, input logic final_flag,
                            input logic with_abort);
    int   lim;
    int   abort_at;
    int   h;
    int   l;
    logic flag;
    lim      = (cur_timeout == 0) ? 1 : int'(cur_timeout);
    abort_at = with_abort ? $urandom_range(0, n_bytes * 9) : -1;
    send_run(1'b1, $urandom_range(1, 3));
    if (abort_at == 0) begin
      send_run(1'b0, lim + 1);
      return;
    end
    send_run(1'b0, phase_len(span));
    for (int k = 1; k <= n_bytes * 9; k++) begin
      if (k == abort_at) begin
        if ($urandom_range(0, 1) == 1) begin
          send_run(1'b1, lim + 1);
        end else begin
          send_run(1'b1, 1);
          send_run(1'b0, lim + 1);
        end
        return;
      end
      flag = (k == n_bytes * 9) ? final_flag : 1'b0;
      if (k % 9 != 0) begin
        h = phase_len(span);
        l = phase_len(span);
      end else if (flag && lim > 1) begin
        l = $urandom_range(1, (span < lim - 1) ? span : lim - 1);
        h = $urandom_range(l + 1, (l + span < lim) ? l + span : lim);
      end else begin
        l = phase_len(span);
        h = $urandom_range(1, l);
      end
      send_fragment(h, l);
    end
    send_run(1'b1, $urandom_range(1, 2));
  endtask

  task automatic drain_words();
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (word_sb.expected_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [pwsr_pkg::AddrWidth-1:0] addr,
                                input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == TimeoutAddr) begin
      word_sb.tick_limit = value[7:0];
    end else begin
      word_sb.byte_capacity = value[6:0];
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic run_phase(input logic [7:0] tmo, input logic [6:0] cap, input int span,
                           input int unsigned budget);
    int          capeff;
    int          n_bytes;
    int          pick;
    int unsigned base;
    drain_words();
    write_register(TimeoutAddr, 32'(tmo));
    write_register(CapacityAddr, 32'(cap));
    cur_timeout = tmo;
    capeff      = (cap > pwsr_pkg::MaxFrameBytes) ? pwsr_pkg::MaxFrameBytes :
                  ((cap == 0) ? 1 : int'(cap));
    settings_run++;
    base = word_sb.samples;
    while (word_sb.samples - base < budget) begin
      steady_in = ($urandom_range(0, 3) == 0);
      pick      = $urandom_range(0, 9);
      n_bytes   = $urandom_range(1, (capeff < 4) ? capeff : 4);
      if (pick == 0) begin
        repeat ($urandom_range(4, 24)) send_sample(logic'($urandom_range(0, 1)));
      end else if (pick == 1) begin
        send_frame(n_bytes, span, 1'b1, 1'b1);
      end else if (pick == 2 && capeff <= 6) begin
        send_frame(capeff + 1, span, 1'b1, 1'b0);
      end else begin
        send_frame(n_bytes, span,
                   (n_bytes == capeff) ? logic'($urandom_range(0, 1)) : 1'b1, 1'b0);
      end
    end
  endtask

  initial begin
    int unsigned sample_base;
    int unsigned word_base;
    logic [7:0]  tmo;
    logic [6:0]  cap;
    rst_ni            = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    in_bus.valid      = 1'b0;
    in_bus.line_level = 1'b1;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // The line is taken as high out of reset, so a first low sample opens a frame.
    send_run(1'b0, 2);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h3C, 1'b1);
    send_run(1'b1, 2);
    // Wide pulses whose high plus low count no longer fits in eight bits.
    send_run(1'b0, 1);
    send_fragment(255, 1);
    send_fragment(128, 128);
    send_fragment(129, 128);
    send_fragment(1, 255);
    repeat (4) send_fragment(1, 1);
    send_fragment(2, 1);
    send_run(1'b1, 2);

    run_phase(8'd0, 7'd0, 2, 60);
    run_phase(8'd1, 7'd1, 1, 40);
    run_phase(8'd255, 7'd127, 4, 80);
    // A full frame whose end flag never comes, so the clamped capacity closes it.
    send_frame(pwsr_pkg::MaxFrameBytes, 1, 1'b0, 1'b0);
    run_phase(8'd2, 7'd64, 3, 80);
    run_phase(8'd128, 7'd5, 5, 80);

    sample_base = word_sb.samples;
    word_base   = word_sb.words_checked;
    while (word_sb.samples - sample_base < RandomSamples ||
           word_sb.words_checked - word_base < RandomWords) begin
      tmo = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 255)) :
                                          8'($urandom_range(2, 12));
      cap = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(1, 127)) :
                                          7'($urandom_range(1, 6));
      run_phase(tmo, cap, $urandom_range(2, 6), 100);
    end

    drain_words();
    repeat (2 * DrainCycles) @(posedge clk_i);
    $display("Drove %0d line samples under %0d register settings after the reset defaults.",
             word_sb.samples, settings_run);
    $display("Checked %0d words: %0d data bytes and %0d timeout aborts, %0d errors.",
             word_sb.words_checked, word_sb.bytes_predicted, word_sb.aborts_predicted,
             word_sb.errors);
    if (word_sb.errors == 0 && word_sb.expected_words.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
